### hdl/lcdmux_pkg.sv
// Shared types, constants, microcode table and segment decoder for the
// segment LCD multiplex driver. No dependencies.
package lcdmux_pkg;

    // Request kinds carried in s_tuser
    localparam logic [2:0] REQ_ADVANCE = 3'd0;
    localparam logic [2:0] REQ_TENS    = 3'd1;
    localparam logic [2:0] REQ_ONES    = 3'd2;
    localparam logic [2:0] REQ_VOLT    = 3'd3;
    localparam logic [2:0] REQ_TEMP    = 3'd4;

    // Datapath operations
    localparam logic [2:0] OP_NOP      = 3'd0;
    localparam logic [2:0] OP_ADVANCE  = 3'd1;
    localparam logic [2:0] OP_TENS     = 3'd2;
    localparam logic [2:0] OP_ONES     = 3'd3;
    localparam logic [2:0] OP_VOLT     = 3'd4;
    localparam logic [2:0] OP_TEMP_MUL = 3'd5;
    localparam logic [2:0] OP_TEMP_DIG = 3'd6;
    localparam logic [2:0] OP_EMIT     = 3'd7;

    // Sequencer jump conditions
    localparam logic [1:0] CND_GOTO     = 2'd0;
    localparam logic [1:0] CND_WAIT_IN  = 2'd1;
    localparam logic [1:0] CND_DISPATCH = 2'd2;
    localparam logic [1:0] CND_WAIT_OUT = 2'd3;

    // Program steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FETCH    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ADV      = 4'd2; // dispatch base, +req_type
    localparam logic [STEP_W-1:0] STEP_TENS     = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ONES     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_VOLT     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_TEMP     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_TEMP2    = 4'd8;

    // Voltage bands (mV) and divisor values
    localparam logic [12:0] MV_BAND1 = 13'd2400;
    localparam logic [12:0] MV_BAND2 = 13'd2800;
    localparam logic [12:0] MV_BAND3 = 13'd3200;
    localparam logic [12:0] MV_BAND4 = 13'd3600;
    localparam logic [6:0]  DIV_1    = 7'd1;
    localparam logic [6:0]  DIV_2    = 7'd2;
    localparam logic [6:0]  DIV_4    = 7'd4;
    localparam logic [6:0]  DIV_16   = 7'd16;
    localparam logic [6:0]  DIV_100  = 7'd100;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd138;

    // x / 100 = (x * 83887) >> 23, exact for 16-bit x
    localparam logic [16:0] RECIP_100 = 17'd83887;
    localparam int          RECIP_100_SH = 23;
    // t / 10 = (t * 205) >> 11, exact for 8-bit t
    localparam logic [12:0] RECIP_10 = 13'd205;
    localparam int          RECIP_10_SH = 11;
    localparam int          PROD_W = 33;

    typedef struct packed {
        logic       take_in;
        logic [1:0] cond;
        logic [2:0] op;
        logic [STEP_W-1:0] target;
    } lcdmux_cw_t;

    typedef struct packed {
        logic [2:0] op;
        logic       exec;
        logic       latch_in;
    } lcdmux_ctl_t;

    typedef struct packed {
        logic [15:0] duration;
        logic        pwm_level;
        logic [6:0]  seg_lines;
        logic [2:0]  com_lines;
        logic [2:0]  phase;
    } lcdmux_out_t;

    function automatic lcdmux_cw_t ucode(input logic [STEP_W-1:0] step);
        lcdmux_cw_t cw;
        cw = '{take_in: 1'b0, cond: CND_GOTO, op: OP_NOP, target: STEP_FETCH};
        unique case (step)
            STEP_FETCH:    cw = '{1'b1, CND_WAIT_IN,  OP_NOP,      STEP_DISPATCH};
            STEP_DISPATCH: cw = '{1'b0, CND_DISPATCH, OP_NOP,      STEP_FETCH};
            STEP_ADV:      cw = '{1'b0, CND_GOTO,     OP_ADVANCE,  STEP_EMIT};
            STEP_TENS:     cw = '{1'b0, CND_GOTO,     OP_TENS,     STEP_FETCH};
            STEP_ONES:     cw = '{1'b0, CND_GOTO,     OP_ONES,     STEP_FETCH};
            STEP_VOLT:     cw = '{1'b0, CND_GOTO,     OP_VOLT,     STEP_FETCH};
            STEP_TEMP:     cw = '{1'b0, CND_GOTO,     OP_TEMP_MUL, STEP_TEMP2};
            STEP_EMIT:     cw = '{1'b0, CND_WAIT_OUT, OP_EMIT,     STEP_FETCH};
            STEP_TEMP2:    cw = '{1'b0, CND_GOTO,     OP_TEMP_DIG, STEP_FETCH};
            default:       cw = '{1'b0, CND_GOTO,     OP_NOP,      STEP_FETCH};
        endcase
        return cw;
    endfunction

    // Segment code: bit0 A .. bit6 G; codes above nine light nothing
    function automatic logic [6:0] digit_segs(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

### hdl/segment_lcd_mux_driver_top.sv
// Channel   | Dir | Fields (low bit first)
// s_axis    | in  | tdata: supply_mv[12:0], temperature[20:13]; tuser: req_type[2:0]
// m_axis    | out | tdata: phase, com_lines, seg_lines, pwm_level, duration
// cfg       | in  | cfg_data: phase_ticks[15:0]
//
// Each request runs through the microcode steps fetch, dispatch and execute;
// a phase advance adds an emit step and a temperature request a second digit
// step; a reserved code skips execute. Reset puts the step counter at fetch.
// A stalled result holds in the output register; the next request is taken
// while it waits, and only a second advance stalls at its emit step.
// Top level: microcoded sequencer and output handshake. Depends on
// lcdmux_pkg and lcdmux_dp.
module segment_lcd_mux_driver_top
    import lcdmux_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // supply_mv[12:0], temperature[20:13]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // phase[2:0], com_lines[5:3], seg_lines[12:6],
                                   // pwm_level[13], duration[29:14]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    lcdmux_cw_t        cw;
    lcdmux_ctl_t       ctl;
    lcdmux_out_t       out_item;
    logic [2:0]        req;
    logic              s_xfer, slot_free;

    assign cw        = ucode(step_reg);
    assign s_tready  = cw.take_in;
    assign s_xfer    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        ctl.op       = cw.op;
        ctl.latch_in = s_xfer;
        ctl.exec     = 1'b1;
        step_next    = cw.target;
        unique case (cw.cond)
            CND_WAIT_IN:
                if (!s_xfer) step_next = step_reg;
            CND_DISPATCH:
                step_next = (req <= REQ_TEMP) ? STEP_W'(STEP_ADV + {1'b0, req})
                                              : STEP_FETCH;
            CND_WAIT_OUT:
            begin
                ctl.exec = slot_free;
                if (!slot_free) step_next = step_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
            m_tvalid_next = 1'b0;
        if (ctl.exec && cw.op == OP_EMIT)
            m_tvalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_FETCH;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    lcdmux_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_req    (s_tuser),
        .in_mv     (s_tdata[12:0]),
        .in_temp   (s_tdata[20:13]),
        .cfg_we    (cfg_valid),
        .cfg_wdata (cfg_data),
        .req       (req),
        .out_item  (out_item)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_item};

endmodule

### hdl/lcdmux_dp.sv
// Datapath of the LCD multiplex driver: display state, contrast divisor,
// the product register shared by both reciprocal multiplies, and the
// pin/duration output register. Depends on lcdmux_pkg.
module lcdmux_dp
    import lcdmux_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lcdmux_ctl_t ctl,
    input  logic [2:0]  in_req,
    input  logic [12:0] in_mv,
    input  logic [7:0]  in_temp,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic [2:0]  req,
    output lcdmux_out_t out_item
);

    logic [15:0] ticks_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  tens_reg, tens_next;
    logic [3:0]  ones_reg, ones_next;
    logic [6:0]  div_reg, div_next;
    logic [2:0]  req_reg;
    logic [12:0] mv_reg;
    logic [7:0]  temp_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    lcdmux_out_t out_reg, out_next;

    logic [4:0]  quot;
    logic [7:0]  quot_x10;
    logic [6:0]  st, so;
    logic [15:0] dur;

    assign req      = req_reg;
    assign out_item = out_reg;

    always_comb
    begin
        phase_next = phase_reg;
        tens_next  = tens_reg;
        ones_next  = ones_reg;
        div_next   = div_reg;
        prod_next  = prod_reg;
        quot       = prod_reg[RECIP_10_SH+4:RECIP_10_SH];
        quot_x10   = 8'({3'b000, quot} * 8'd10);
        if (ctl.exec)
        begin
            case (ctl.op)
                OP_ADVANCE:
                begin
                    phase_next = phase_reg + 3'd1;
                    prod_next  = PROD_W'(ticks_reg * RECIP_100);
                end
                OP_TENS:
                    tens_next = (tens_reg >= 4'd9) ? 4'd0 : tens_reg + 4'd1;
                OP_ONES:
                begin
                    if (ones_reg >= 4'd9)
                    begin
                        ones_next = 4'd0;
                        tens_next = (tens_reg >= 4'd9) ? 4'd0 : tens_reg + 4'd1;
                    end
                    else
                    begin
                        ones_next = ones_reg + 4'd1;
                    end
                end
                OP_VOLT:
                begin
                    if (mv_reg <= MV_BAND1)      div_next = DIV_1;
                    else if (mv_reg <= MV_BAND2) div_next = DIV_2;
                    else if (mv_reg <= MV_BAND3) div_next = DIV_4;
                    else if (mv_reg <= MV_BAND4) div_next = DIV_16;
                end
                OP_TEMP_MUL:
                    prod_next = PROD_W'(temp_reg * RECIP_10);
                OP_TEMP_DIG:
                begin
                    ones_next = 4'(temp_reg - quot_x10);
                    // hundreds dropped: quotient is at most 25
                    if (quot >= 5'd20)      tens_next = 4'(quot - 5'd20);
                    else if (quot >= 5'd10) tens_next = 4'(quot - 5'd10);
                    else                    tens_next = quot[3:0];
                end
                default: ;
            endcase
        end
    end

    // Output word for the phase just entered
    always_comb
    begin
        st = digit_segs(tens_reg);
        so = digit_segs(ones_reg);
        out_next = out_reg;
        out_next.phase = phase_reg;
        unique case (phase_reg)
            3'd0: begin out_next.com_lines = 3'd0; out_next.seg_lines = 7'h7F;
                        out_next.pwm_level = 1'b0; end
            3'd1: begin out_next.com_lines = 3'd7; out_next.seg_lines = 7'h00;
                        out_next.pwm_level = 1'b1; end
            3'd2: begin out_next.com_lines = 3'd6; out_next.pwm_level = 1'b0;
                        out_next.seg_lines = {1'b0, so[1], so[0], so[5],
                                              st[1], st[0], st[5]}; end
            3'd3: begin out_next.com_lines = 3'd1; out_next.seg_lines = 7'h00;
                        out_next.pwm_level = 1'b1; end
            3'd4: begin out_next.com_lines = 3'd5; out_next.pwm_level = 1'b0;
                        out_next.seg_lines = {1'b0, so[2], so[6], so[4],
                                              st[2], st[6], st[4]}; end
            3'd5: begin out_next.com_lines = 3'd2; out_next.seg_lines = 7'h00;
                        out_next.pwm_level = 1'b1; end
            3'd6: begin out_next.com_lines = 3'd3; out_next.pwm_level = 1'b0;
                        out_next.seg_lines = {2'b00, so[3], 1'b0, 1'b1,
                                              st[3], 1'b0}; end
            default: begin out_next.com_lines = 3'd4; out_next.seg_lines = 7'h00;
                           out_next.pwm_level = 1'b1; end
        endcase
        if (phase_reg > 3'd1)
            dur = ticks_reg;
        else
        begin
            case (div_reg)
                DIV_2:   dur = {1'b0, ticks_reg[15:1]};
                DIV_4:   dur = {2'b00, ticks_reg[15:2]};
                DIV_16:  dur = {4'b0000, ticks_reg[15:4]};
                DIV_100: dur = 16'(prod_reg[PROD_W-1:RECIP_100_SH]);
                default: dur = ticks_reg;
            endcase
        end
        out_next.duration = dur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= PHASE_TICKS_RST;
            phase_reg <= 3'd0;
            tens_reg  <= 4'd0;
            ones_reg  <= 4'd0;
            div_reg   <= DIV_100;
        end
        else
        begin
            if (cfg_we)
                ticks_reg <= cfg_wdata;
            phase_reg <= phase_next;
            tens_reg  <= tens_next;
            ones_reg  <= ones_next;
            div_reg   <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            req_reg  <= in_req;
            mv_reg   <= in_mv;
            temp_reg <= in_temp;
        end
        prod_reg <= prod_next;
        if (ctl.exec && ctl.op == OP_EMIT)
            out_reg <= out_next;
    end

endmodule

### hdl/lcdmux_checker.sv
// Port-level checks for the LCD multiplex driver, bound to the top level.
// Depends on lcdmux_pkg and the top level's ports.
module lcdmux_checker
    import lcdmux_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled result is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // one request in flight: input is not ready right after a transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // a non-advance request never starts a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != REQ_ADVANCE |=> ##1 !$rose(m_tvalid))
        else $error("result after a non-advance request");

    // odd phases drive no segment and a high PWM level
    a_odd_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[12:6] == 7'h00 && m_tdata[13])
        else $error("odd phase pin levels wrong");

    // contrast phase zero: all segments high, commons low
    a_phase0: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == 3'd0 |->
            m_tdata[5:3] == 3'd0 && m_tdata[12:6] == 7'h7F && !m_tdata[13])
        else $error("phase zero pin levels wrong");

endmodule

bind segment_lcd_mux_driver_top lcdmux_checker u_lcdmux_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/segment_lcd_mux_driver_top_tb.sv
// Self-checking testbench for segment_lcd_mux_driver_top: a directed table, then random
// request streams under several phase_ticks settings, checked against an in-bench predictor.
// Depends on lcdmux_pkg and the RTL of segment_lcd_mux_driver_top.
`timescale 1ns / 100ps

module segment_lcd_mux_driver_top_tb;
    import lcdmux_pkg::*;

    // Request codes the block ignores
    localparam logic [2:0] REQ_RSVD5 = 3'd5;
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    localparam int N_ROWS      = 25;
    localparam int N_SETTINGS  = 6;
    localparam int ITEMS_PER   = 200;
    localparam int DRAIN_CYC   = 12;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYC    = 400;
    localparam int CYCLE_LIMIT = 300000;

    // 7-segment font, bit0 A .. bit6 G; codes above nine are blank
    localparam logic [6:0] FONT [0:15] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    typedef struct packed {
        logic [2:0]  req;
        logic [12:0] mv;
        logic [7:0]  temp;
        logic        typed;
        lcdmux_out_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // supply_mv[12:0], temperature[20:13]
    logic [2:0]  s_tuser;   // req_type[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // phase[2:0], com_lines[5:3], seg_lines[12:6],
                            // pwm_level[13], duration[29:14]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // predictor state
    logic [2:0]  drv_phase;
    logic [3:0]  tens_d;
    logic [3:0]  ones_d;
    logic [6:0]  contrast_div;
    logic [15:0] base_ticks;

    lcdmux_out_t drive_q [$];
    stim_row_t   dir_rows [0:N_ROWS-1];
    int          err_count;
    int          items_sent;
    int          cycles;
    bit          quiet;

    segment_lcd_mux_driver_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic lcdmux_out_t drive(input logic [2:0] ph, input logic [2:0] com,
                                          input logic [6:0] seg, input logic pwm,
                                          input logic [15:0] dur);
        lcdmux_out_t d;
        d.phase     = ph;
        d.com_lines = com;
        d.seg_lines = seg;
        d.pwm_level = pwm;
        d.duration  = dur;
        return d;
    endfunction

    function automatic stim_row_t row(input logic [2:0] req, input logic [12:0] mv,
                                      input logic [7:0] temp, input logic typed,
                                      input lcdmux_out_t want);
        stim_row_t r;
        r.req   = req;
        r.mv    = mv;
        r.temp  = temp;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [3:0] wrap_digit(input logic [3:0] d);
        return (d >= 4'd9) ? 4'd0 : d + 4'd1;
    endfunction

    // Apply one request to the predicted state; emits is set for a phase advance.
    task automatic next_phase_drive(input logic [2:0] req, input logic [12:0] mv,
                                    input logic [7:0] temp, output bit emits,
                                    output lcdmux_out_t res);
        logic [6:0] tf;
        logic [6:0] of;
        logic [6:0] seg;
        logic [2:0] com;
        emits = 1'b0;
        res   = '0;
        case (req)
            REQ_TENS: tens_d = wrap_digit(tens_d);
            REQ_ONES:
            begin
                if (ones_d >= 4'd9)
                begin
                    ones_d = 4'd0;
                    tens_d = wrap_digit(tens_d);
                end
                else
                    ones_d = ones_d + 4'd1;
            end
            REQ_VOLT:
            begin
                if (mv <= MV_BAND1)      contrast_div = DIV_1;
                else if (mv <= MV_BAND2) contrast_div = DIV_2;
                else if (mv <= MV_BAND3) contrast_div = DIV_4;
                else if (mv <= MV_BAND4) contrast_div = DIV_16;
            end
            REQ_TEMP:
            begin
                ones_d = 4'(temp % 8'd10);
                tens_d = 4'((temp / 8'd10) % 8'd10);
            end
            REQ_ADVANCE:
            begin
                emits     = 1'b1;
                drv_phase = drv_phase + 3'd1;
                tf        = FONT[tens_d];
                of        = FONT[ones_d];
                seg       = 7'h00;
                case (drv_phase)
                    3'd0: begin com = 3'd0; seg = 7'h7F; end
                    3'd1: com = 3'd7;
                    3'd2:
                    begin
                        com = 3'd6;
                        seg = {1'b0, of[1], of[0], of[5], tf[1], tf[0], tf[5]};
                    end
                    3'd3: com = 3'd1;
                    3'd4:
                    begin
                        com = 3'd5;
                        seg = {1'b0, of[2], of[6], of[4], tf[2], tf[6], tf[4]};
                    end
                    3'd5: com = 3'd2;
                    3'd6:
                    begin
                        com = 3'd3;
                        seg = {2'b00, of[3], 1'b0, 1'b1, tf[3], 1'b0};
                    end
                    default: com = 3'd4;
                endcase
                // contrast pair runs shortened by the supply-dependent divisor
                res = drive(drv_phase, com, seg, drv_phase[0],
                            (drv_phase > 3'd1) ? base_ticks
                                               : base_ticks / {9'd0, contrast_div});
            end
            default: ;
        endcase
    endtask

    task automatic send_req(input logic [2:0] req, input logic [12:0] mv,
                            input logic [7:0] temp, input logic typed,
                            input lcdmux_out_t want);
        bit          emits;
        lcdmux_out_t pred;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, temp, mv};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        next_phase_drive(req, mv, temp, emits, pred);
        if (emits)
            drive_q.push_back(typed ? want : pred);
    endtask

    // Wait out outstanding results and any non-emitting request still in flight, then write phase_ticks.
    task automatic write_phase_ticks(input logic [15:0] val);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (drive_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        base_ticks = val;
    endtask

    function automatic logic [12:0] pick_mv();
        case ($urandom_range(0, 11))
            0:       return 13'd0;
            1:       return MV_BAND1;
            2:       return MV_BAND1 + 13'd1;
            3:       return MV_BAND2;
            4:       return MV_BAND2 + 13'd1;
            5:       return MV_BAND3;
            6:       return MV_BAND3 + 13'd1;
            7:       return MV_BAND4;
            8:       return MV_BAND4 + 13'd1;
            9:       return 13'h1FFF;
            default: return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    // Receiver: random stall bursts, plus one long hold so the block backs up
    initial
    begin : rx_side
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        lcdmux_out_t got;
        lcdmux_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[29:0];
            if (drive_q.size() == 0)
                report_mismatch("result with nothing pending, phase", got.phase, -1);
            else
            begin
                want = drive_q.pop_front();
                if (got.phase != want.phase)
                    report_mismatch("phase", got.phase, want.phase);
                if (got.com_lines != want.com_lines)
                    report_mismatch("com_lines", got.com_lines, want.com_lines);
                if (got.seg_lines != want.seg_lines)
                    report_mismatch("seg_lines", got.seg_lines, want.seg_lines);
                if (got.pwm_level != want.pwm_level)
                    report_mismatch("pwm_level", got.pwm_level, want.pwm_level);
                if (got.duration != want.duration)
                    report_mismatch("duration", got.duration, want.duration);
            end
        end
    end

    initial
    begin : stim
        logic [15:0] settings [0:N_SETTINGS-1];
        logic [2:0]  req;
        int          r;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_ADVANCE;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        cycles       = 0;
        err_count    = 0;
        items_sent   = 0;
        quiet        = 1'b0;
        drv_phase    = 3'd0;
        tens_d       = 4'd0;
        ones_d       = 4'd0;
        contrast_div = DIV_100;
        base_ticks   = PHASE_TICKS_RST;

        // typed rows: reset state, then the contrast pair with divisor 1
        dir_rows[0]  = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b1,
                           drive(3'd1, 3'd7, 7'h00, 1'b1, 16'd1));
        dir_rows[1]  = row(REQ_TEMP, 13'd0, 8'd255, 1'b0, '0);
        dir_rows[2]  = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b0, '0);
        dir_rows[3]  = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b0, '0);
        dir_rows[4]  = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b0, '0);
        dir_rows[5]  = row(REQ_VOLT, MV_BAND1, 8'd0, 1'b0, '0);
        dir_rows[6]  = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b0, '0);
        dir_rows[7]  = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b0, '0);
        dir_rows[8]  = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b0, '0);
        dir_rows[9]  = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b1,
                           drive(3'd0, 3'd0, 7'h7F, 1'b0, PHASE_TICKS_RST));
        dir_rows[10] = row(REQ_VOLT, 13'h1FFF, 8'd0, 1'b0, '0);
        dir_rows[11] = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b1,
                           drive(3'd1, 3'd7, 7'h00, 1'b1, PHASE_TICKS_RST));
        dir_rows[12] = row(REQ_VOLT, MV_BAND1 + 13'd1, 8'd0, 1'b0, '0);
        dir_rows[13] = row(REQ_VOLT, MV_BAND4 + 13'd1, 8'd0, 1'b0, '0);
        dir_rows[14] = row(REQ_TEMP, 13'd0, 8'd99, 1'b0, '0);
        // ones carry out of 99 wraps both digits
        dir_rows[15] = row(REQ_ONES, 13'd0, 8'd0, 1'b0, '0);
        dir_rows[16] = row(REQ_TENS, 13'd0, 8'd0, 1'b0, '0);
        dir_rows[17] = row(REQ_RSVD5, 13'h1FFF, 8'hFF, 1'b0, '0);
        dir_rows[18] = row(REQ_RSVD6, 13'h1FFF, 8'hFF, 1'b0, '0);
        dir_rows[19] = row(REQ_RSVD7, 13'h1FFF, 8'hFF, 1'b0, '0);
        dir_rows[20] = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b0, '0);
        dir_rows[21] = row(REQ_VOLT, MV_BAND3, 8'd0, 1'b0, '0);
        dir_rows[22] = row(REQ_VOLT, MV_BAND4, 8'd0, 1'b0, '0);
        dir_rows[23] = row(REQ_TEMP, 13'd0, 8'd0, 1'b0, '0);
        dir_rows[24] = row(REQ_ADVANCE, 13'd0, 8'd0, 1'b0, '0);

        settings[0] = 16'd65535;
        settings[1] = 16'd1;
        settings[2] = 16'($urandom_range(2, 65534));
        settings[3] = 16'd3;
        settings[4] = 16'($urandom_range(2, 65534));
        settings[5] = 16'd65535;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            send_req(dir_rows[i].req, dir_rows[i].mv, dir_rows[i].temp,
                     dir_rows[i].typed, dir_rows[i].want);

        for (int s = 0; s < N_SETTINGS; s++)
        begin
            write_phase_ticks(settings[s]);
            if (s == N_SETTINGS - 1)
                quiet = 1'b1;
            for (int n = 0; n < ITEMS_PER; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)      req = REQ_ADVANCE;
                else if (r < 58) req = REQ_TENS;
                else if (r < 66) req = REQ_ONES;
                else if (r < 80) req = REQ_VOLT;
                else if (r < 94) req = REQ_TEMP;
                else             req = 3'($urandom_range(5, 7));
                send_req(req, (req == REQ_VOLT) ? pick_mv() : 13'($urandom_range(0, 8191)),
                         8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (drive_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
